// ----- sv/pcc_pkg.sv -----
// shared constants, types and helpers for the path corridor check
`timescale 1ns / 1ps

package pcc_pkg;

   // default coordinate width, signed q16.8
   localparam int COORD_BITS_DEF = 24;

   // fixed field widths
   localparam int RADIUS_W = 50;
   localparam int LEN_W    = 25;
   localparam int TRACK_W  = 26;
   localparam int QBITS    = 25;

   localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

   // partial product slice width for the wide multipliers
   localparam int MUL_CHUNK = 16;

   // queue between front and back
   localparam int QUEUE_DEPTH = 8;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // verdict codes
   typedef logic [1:0] verdict_type;
   localparam verdict_type VERDICT_CAPTURE  = 2'd0;
   localparam verdict_type VERDICT_BEHIND   = 2'd1;
   localparam verdict_type VERDICT_CORR_IN  = 2'd2;
   localparam verdict_type VERDICT_CORR_OUT = 2'd3;

   // queue status seen by the front
   typedef struct packed {
      logic              empty;
      logic [QCNT_W-1:0] count;
   } queue_status_type;

   // queue entry width: capture, zero length, dot sign, then |d|^2, |dot|, |cross|
   function automatic int entry_w(input int coord_bits);
      return 3 + 6 * (coord_bits + 1);
   endfunction

endpackage

// ----- sv/pcc_queue.sv -----
// short queue of classified transactions between front and back
`timescale 1ns / 1ps

module pcc_queue import pcc_pkg::*; #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output queue_status_type status
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   logic [WIDTH-1:0]  mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wptr_ff, wptr_in;
   logic [PTR_W-1:0]  rptr_ff, rptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   // pointer and fill count update
   always_comb begin
      wptr_in  = push ? wptr_ff + PTR_W'(1) : wptr_ff;
      rptr_in  = pop ? rptr_ff + PTR_W'(1) : rptr_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (!push && pop) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wptr_ff] <= push_data;
      end
   end

   assign pop_data     = mem_ff[rptr_ff];
   assign status.empty = (count_ff == '0);
   assign status.count = count_ff;

endmodule

// ----- sv/pcc_front.sv -----
// front: differences, products, sums and capture classification
`timescale 1ns / 1ps

module pcc_front import pcc_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [COORD_BITS-1:0]       req_pose_x,
   input  logic signed [COORD_BITS-1:0]       req_pose_z,
   input  logic signed [COORD_BITS-1:0]       req_head_x,
   input  logic signed [COORD_BITS-1:0]       req_head_z,
   input  logic signed [COORD_BITS-1:0]       req_next_x,
   input  logic signed [COORD_BITS-1:0]       req_next_z,
   input  logic [RADIUS_W-1:0]                radius_sq,
   input  queue_status_type                   q_status,
   output logic                               push_valid,
   output logic [entry_w(COORD_BITS)-1:0]     push_entry
);

   localparam int W    = COORD_BITS + 1;
   localparam int SQW  = 2 * W;
   localparam int CMPW = SQW + RADIUS_W;

   typedef struct packed {
      logic           cap;
      logic           zero;
      logic           dneg;
      logic [SQW-1:0] s2;
      logic [SQW-1:0] dmag;
      logic [SQW-1:0] cmag;
   } entry_type;

   logic accept;
   logic [QCNT_W:0] pledge;

   // stage 1: differences
   logic                v1_ff;
   logic signed [W-1:0] tx_ff, tz_ff, sx_ff, sz_ff;
   logic signed [W-1:0] tx_in, tz_in, sx_in, sz_in;

   // stage 2: products
   logic                  v2_ff;
   logic signed [SQW-1:0] ptx_ff, ptz_ff, psx_ff, psz_ff;
   logic signed [SQW-1:0] pd1_ff, pd2_ff, pc1_ff, pc2_ff;

   // stage 3: sums
   logic                  v3_ff;
   logic [SQW-1:0]        t2_ff, s2_ff, t2_in, s2_in;
   logic signed [SQW:0]   dot_ff, crs_ff, dot_in, crs_in;

   // stage 4: classification and magnitudes
   logic                  v4_ff;
   entry_type             entry_ff, entry_in;
   logic signed [SQW:0]   dot_neg, crs_neg;

   // room is pledged for every transaction still inside the front
   assign pledge = (QCNT_W + 1)'(q_status.count) + (QCNT_W + 1)'(v1_ff)
                 + (QCNT_W + 1)'(v2_ff) + (QCNT_W + 1)'(v3_ff) + (QCNT_W + 1)'(v4_ff);
   assign req_stall = (pledge >= (QCNT_W + 1)'(QUEUE_DEPTH));
   assign accept    = req_valid && !req_stall;

   // differences from the head node
   assign tx_in = W'(req_pose_x) - W'(req_head_x);
   assign tz_in = W'(req_pose_z) - W'(req_head_z);
   assign sx_in = W'(req_next_x) - W'(req_head_x);
   assign sz_in = W'(req_next_z) - W'(req_head_z);

   // sums of products
   assign t2_in  = SQW'(ptx_ff) + SQW'(ptz_ff);
   assign s2_in  = SQW'(psx_ff) + SQW'(psz_ff);
   assign dot_in = (SQW + 1)'(pd1_ff) + (SQW + 1)'(pd2_ff);
   assign crs_in = (SQW + 1)'(pc1_ff) - (SQW + 1)'(pc2_ff);

   // capture test, signs and magnitudes
   assign dot_neg = -dot_ff;
   assign crs_neg = -crs_ff;
   always_comb begin
      entry_in.cap  = (CMPW'(t2_ff) <= CMPW'(radius_sq));
      entry_in.zero = (s2_ff == '0);
      entry_in.dneg = dot_ff[SQW];
      entry_in.s2   = s2_ff;
      entry_in.dmag = dot_ff[SQW] ? dot_neg[SQW-1:0] : dot_ff[SQW-1:0];
      entry_in.cmag = crs_ff[SQW] ? crs_neg[SQW-1:0] : crs_ff[SQW-1:0];
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   // payload stages
   always_ff @(posedge clock) begin
      tx_ff <= tx_in;
      tz_ff <= tz_in;
      sx_ff <= sx_in;
      sz_ff <= sz_in;

      ptx_ff <= SQW'(tx_ff) * SQW'(tx_ff);
      ptz_ff <= SQW'(tz_ff) * SQW'(tz_ff);
      psx_ff <= SQW'(sx_ff) * SQW'(sx_ff);
      psz_ff <= SQW'(sz_ff) * SQW'(sz_ff);
      pd1_ff <= SQW'(sx_ff) * SQW'(tx_ff);
      pd2_ff <= SQW'(sz_ff) * SQW'(tz_ff);
      pc1_ff <= SQW'(sx_ff) * SQW'(tz_ff);
      pc2_ff <= SQW'(sz_ff) * SQW'(tx_ff);

      t2_ff  <= t2_in;
      s2_ff  <= s2_in;
      dot_ff <= dot_in;
      crs_ff <= crs_in;

      entry_ff <= entry_in;
   end

   assign push_valid = v4_ff;
   assign push_entry = entry_ff;

endmodule

// ----- sv/pcc_back.sv -----
// back: square root, division and corridor test pipeline with output register
`timescale 1ns / 1ps

module pcc_back import pcc_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           q_empty,
   input  logic [entry_w(COORD_BITS)-1:0] q_entry,
   output logic                           q_pop,
   input  logic [RADIUS_W-1:0]            radius_sq,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [1:0]                     rsp_verdict,
   output logic                           rsp_still_valid,
   output logic [LEN_W-1:0]               rsp_seg_length,
   output logic signed [TRACK_W-1:0]      rsp_along_track
);

   localparam int LW   = COORD_BITS + 1;
   localparam int SQW  = 2 * LW;
   localparam int RW   = LW + 3;
   localparam int NCH  = (SQW + MUL_CHUNK - 1) / MUL_CHUNK;
   localparam int PW   = NCH * MUL_CHUNK;
   localparam int C2W  = 2 * SQW;
   localparam int RSW  = SQW + RADIUS_W;
   localparam int XW   = SQW + QBITS;
   localparam int NST  = LW + QBITS;
   localparam int MW   = LW + LEN_W;
   localparam int CW   = C2W + RSW;

   typedef struct packed {
      logic           cap;
      logic           zero;
      logic           dneg;
      logic [SQW-1:0] s2;
      logic [SQW-1:0] dmag;
      logic [SQW-1:0] cmag;
   } entry_type;

   typedef struct packed {
      logic             vld;
      logic             cap;
      logic             zero;
      logic             dneg;
      logic [SQW-1:0]   s2;
      logic [SQW-1:0]   dmag;
      logic [SQW-1:0]   cmag;
      logic [RW-1:0]    srem;
      logic [LW-1:0]    root;
      logic [C2W-1:0]   c2;
      logic [RSW-1:0]   rs;
      logic [SQW-1:0]   drem;
      logic [QBITS-1:0] quo;
      logic             big;
   } stage_type;

   entry_type ent;
   stage_type rec0;
   stage_type st_ff [NST];
   stage_type st_in [NST];
   stage_type last;
   logic      adv;

   logic                       rsp_valid_ff;
   verdict_type                verdict_ff, verdict_in;
   logic                       still_ff, still_in;
   logic [LEN_W-1:0]           len_ff, len_in;
   logic [TRACK_W-1:0]         track_ff, track_in;

   logic [MW-1:0]      root_ext;
   logic [LEN_W-1:0]   len_sat;
   logic [TRACK_W-1:0] q_full;
   logic               corr_in;

   // whole pipeline moves when the output register can take a transaction
   assign adv   = !rsp_valid_ff || !rsp_stall;
   assign q_pop = adv && !q_empty;

   // entry record
   assign ent = entry_type'(q_entry);
   always_comb begin
      rec0      = '0;
      rec0.vld  = q_pop;
      rec0.cap  = ent.cap;
      rec0.zero = ent.zero;
      rec0.dneg = ent.dneg;
      rec0.s2   = ent.s2;
      rec0.dmag = ent.dmag;
      rec0.cmag = ent.cmag;
      rec0.drem = ent.dmag;
   end

   for (genvar i = 0; i < NST; i++) begin : g_stage
      stage_type src;

      if (i == 0) begin : g_first
         assign src = rec0;
      end else begin : g_next
         assign src = st_ff[i-1];
      end

      if (i < LW) begin : g_sqrt
         // one root bit per stage, plus in the first NCH stages a slice of the two wide products
         localparam int P = LW - 1 - i;
         logic [RW-1:0]        rsh, trial;
         logic [C2W-1:0]       c2_part;
         logic [RSW-1:0]       rs_part;

         assign rsh   = {src.srem[RW-3:0], src.s2[2*P+1 -: 2]};
         assign trial = RW'({src.root, 2'b01});

         if (i < NCH) begin : g_mul
            logic [PW-1:0] cpad, spad;

            assign cpad    = PW'(src.cmag);
            assign spad    = PW'(src.s2);
            assign c2_part = C2W'((SQW + MUL_CHUNK)'(src.cmag)
                             * (SQW + MUL_CHUNK)'(cpad[i*MUL_CHUNK +: MUL_CHUNK]))
                             << (i * MUL_CHUNK);
            assign rs_part = RSW'((RADIUS_W + MUL_CHUNK)'(radius_sq)
                             * (RADIUS_W + MUL_CHUNK)'(spad[i*MUL_CHUNK +: MUL_CHUNK]))
                             << (i * MUL_CHUNK);
         end else begin : g_nomul
            assign c2_part = '0;
            assign rs_part = '0;
         end

         always_comb begin
            st_in[i]    = src;
            st_in[i].c2 = src.c2 + c2_part;
            st_in[i].rs = src.rs + rs_part;
            if (rsh >= trial) begin
               st_in[i].srem = rsh - trial;
               st_in[i].root = {src.root[LW-2:0], 1'b1};
            end else begin
               st_in[i].srem = rsh;
               st_in[i].root = {src.root[LW-2:0], 1'b0};
            end
         end
      end else begin : g_div
         // one quotient bit per stage
         localparam int K = QBITS - 1 - (i - LW);
         logic [XW-1:0] dv, dr, diff;

         assign dv   = XW'(src.root) << K;
         assign dr   = XW'(src.drem);
         assign diff = dr - dv;

         always_comb begin
            st_in[i] = src;
            if (i == LW) begin
               st_in[i].big = (XW'(src.dmag) >= (XW'(src.root) << QBITS));
            end
            if (dr >= dv) begin
               st_in[i].drem   = diff[SQW-1:0];
               st_in[i].quo[K] = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            st_ff[i].vld <= 1'b0;
         end else if (adv) begin
            st_ff[i] <= st_in[i];
         end
      end
   end

   assign last = st_ff[NST-1];

   // saturation and final verdict
   assign root_ext = MW'(last.root);
   assign len_sat  = (root_ext > MW'(LEN_MAX)) ? LEN_MAX : root_ext[LEN_W-1:0];
   assign q_full   = last.big ? (TRACK_W'(1) << QBITS) : TRACK_W'(last.quo);
   assign corr_in  = (CW'(last.c2) <= CW'(last.rs));

   always_comb begin
      verdict_in = VERDICT_BEHIND;
      still_in   = 1'b0;
      len_in     = '0;
      track_in   = '0;
      if (last.cap) begin
         verdict_in = VERDICT_CAPTURE;
         still_in   = 1'b1;
      end else if (last.zero) begin
         verdict_in = VERDICT_BEHIND;
      end else if (last.dneg || (last.dmag == '0)) begin
         verdict_in = VERDICT_BEHIND;
         len_in     = len_sat;
         track_in   = TRACK_W'(0) - q_full;
      end else begin
         len_in     = len_sat;
         track_in   = (q_full > TRACK_W'(LEN_MAX)) ? TRACK_W'(LEN_MAX) : q_full;
         verdict_in = corr_in ? VERDICT_CORR_IN : VERDICT_CORR_OUT;
         still_in   = corr_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= last.vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && last.vld) begin
         verdict_ff <= verdict_in;
         still_ff   <= still_in;
         len_ff     <= len_in;
         track_ff   <= track_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_verdict     = verdict_ff;
   assign rsp_still_valid = still_ff;
   assign rsp_seg_length  = len_ff;
   assign rsp_along_track = $signed(track_ff);

endmodule

// ----- sv/path_corridor_check.sv -----
// top level of the path corridor check
//
//   channel  direction  handshake          carries
//   req_     in         req_valid/stall    pose, head node, next node
//   rsp_     out        rsp_valid/stall    verdict, still_valid, length, along track
//   csr_     in         csr_valid/ready    squared capture radius
//
// one transaction per cycle sustained while rsp_stall is low; from the accepting
// edge a transaction passes three further front stages, the queue,
// COORD_BITS + 1 square root stages, 25 divider stages and the output register.
// the square root and divider stages set the depth.
// reset clears all valid bits, the queue and the radius register.
// a stalled output holds the whole back pipeline; the front keeps flowing and
// stalls the input once queue plus in-flight transactions reach the queue depth.
`timescale 1ns / 1ps

module path_corridor_check import pcc_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [COORD_BITS-1:0] req_pose_x,
   input  logic signed [COORD_BITS-1:0] req_pose_z,
   input  logic signed [COORD_BITS-1:0] req_head_x,
   input  logic signed [COORD_BITS-1:0] req_head_z,
   input  logic signed [COORD_BITS-1:0] req_next_x,
   input  logic signed [COORD_BITS-1:0] req_next_z,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [1:0]                   rsp_verdict,
   output logic                         rsp_still_valid,
   output logic [LEN_W-1:0]             rsp_seg_length,
   output logic signed [TRACK_W-1:0]    rsp_along_track,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [RADIUS_W-1:0]          csr_reach_sq
);

   localparam int EW = entry_w(COORD_BITS);

   logic [RADIUS_W-1:0] radius_ff, radius_in;
   logic                push_valid;
   logic [EW-1:0]       push_entry;
   logic [EW-1:0]       pop_entry;
   logic                pop;
   queue_status_type    q_status;

   // configuration register
   assign csr_ready = 1'b1;
   assign radius_in = (csr_valid && csr_ready) ? csr_reach_sq : radius_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= '0;
      end else begin
         radius_ff <= radius_in;
      end
   end

   // front
   pcc_front #(.COORD_BITS(COORD_BITS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_pose_x (req_pose_x),
      .req_pose_z (req_pose_z),
      .req_head_x (req_head_x),
      .req_head_z (req_head_z),
      .req_next_x (req_next_x),
      .req_next_z (req_next_z),
      .radius_sq  (radius_ff),
      .q_status   (q_status),
      .push_valid (push_valid),
      .push_entry (push_entry)
   );

   // queue
   pcc_queue #(.WIDTH(EW)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_data (push_entry),
      .pop       (pop),
      .pop_data  (pop_entry),
      .status    (q_status)
   );

   // back
   pcc_back #(.COORD_BITS(COORD_BITS)) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_status.empty),
      .q_entry         (pop_entry),
      .q_pop           (pop),
      .radius_sq       (radius_ff),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_verdict     (rsp_verdict),
      .rsp_still_valid (rsp_still_valid),
      .rsp_seg_length  (rsp_seg_length),
      .rsp_along_track (rsp_along_track)
   );

   // checks
   a_still_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_still_valid == ((rsp_verdict == VERDICT_CAPTURE)
                                         || (rsp_verdict == VERDICT_CORR_IN))))
      else $error("still_valid disagrees with verdict");

   a_capture_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_verdict == VERDICT_CAPTURE))
         |-> ((rsp_seg_length == '0) && (rsp_along_track == '0)))
      else $error("capture verdict with nonzero lengths");

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      (q_status.count <= QCNT_W'(QUEUE_DEPTH)))
      else $error("queue overfilled");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty)
      else $error("pop from empty queue");

endmodule
